[rtl/dnlcd_pkg.sv]
// Package for the decimal number to display byte converter.
// Holds the shared data types, constants and the one-bit double-dabble step.
// No dependencies.
package dnlcd_pkg;

  // Widths of the input fields and of the decimal work area.
  localparam int unsigned AddrWidth  = 7;
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned NumDigits  = 5;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CountWidth = 3;

  // One conversion cell per bit of the binary value.
  localparam int unsigned NumCells = ValueWidth;

  // Display bus codes.
  localparam logic [7:0] CmdSetAddr = 8'h80;
  localparam logic [7:0] AsciiZero  = 8'h30;

  // Decimal thresholds that set the number of digits shown.
  localparam logic [ValueWidth-1:0] Thresh100   = 16'd100;
  localparam logic [ValueWidth-1:0] Thresh1000  = 16'd1000;
  localparam logic [ValueWidth-1:0] Thresh10000 = 16'd10000;

  // Payload carried along the conversion chain.
  typedef struct packed {
    logic [AddrWidth-1:0]  addr;
    logic [CountWidth-1:0] ndig;
    logic [BcdWidth-1:0]   bcd;
    logic [ValueWidth-1:0] bin;
  } cell_data_t;

  // Request handed from the tail of the chain to the byte serialiser.
  typedef struct packed {
    logic       valid;
    cell_data_t data;
  } tail_req_t;

  // One double-dabble step: correct each decimal digit, then shift one bit in.
  function automatic cell_data_t dabble_step(cell_data_t d);
    cell_data_t          r;
    logic [BcdWidth-1:0] adj;
    adj = d.bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    r = d;
    {r.bcd, r.bin} = {adj, d.bin} << 1;
    return r;
  endfunction

endpackage

[rtl/dnlcd_cell.sv]
// One cell of the binary to decimal conversion chain.
// Performs one double-dabble step per item and registers the result.
// Depends on dnlcd_pkg.
module dnlcd_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic                  valid_i,
  input  dnlcd_pkg::cell_data_t data_i,
  output logic                  valid_o,
  output dnlcd_pkg::cell_data_t data_o
);

  logic                  valid_q;
  dnlcd_pkg::cell_data_t data_q;

  // Occupancy of this cell moves with the whole chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  // The step result is taken whenever the chain moves.
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      data_q <= dnlcd_pkg::dabble_step(data_i);
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/dnlcd_serial.sv]
// Byte serialiser for the display bus.
// Sends the set-address command, then the decimal digits, one byte per cycle.
// Depends on dnlcd_pkg.
module dnlcd_serial (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dnlcd_pkg::tail_req_t req_i,
  output logic                 ready_o,
  output logic                 strobe_o,
  output logic [7:0]           lcd_byte_o,
  output logic                 is_command_o,
  output logic                 last_byte_o
);

  logic [dnlcd_pkg::CountWidth-1:0] rem_q;
  logic                             strobe_q;
  logic [7:0]                       byte_q;
  logic                             cmd_q;
  logic                             last_q;
  logic [dnlcd_pkg::BcdWidth-1:0]   digits_q;
  logic [dnlcd_pkg::BcdWidth-1:0]   aligned;
  logic                             load;

  // A new request is taken once every digit of the previous one has gone out.
  assign ready_o = (rem_q == '0);
  assign load    = req_i.valid && ready_o;

  // Move the most significant digit to be shown into the top nibble.
  always_comb begin
    case (req_i.data.ndig)
      3'd2:    aligned = req_i.data.bcd << 12;
      3'd3:    aligned = req_i.data.bcd << 8;
      3'd4:    aligned = req_i.data.bcd << 4;
      default: aligned = req_i.data.bcd;
    endcase
  end

  // Digit count and output strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q    <= '0;
      strobe_q <= 1'b0;
    end else if (load) begin
      rem_q    <= req_i.data.ndig;
      strobe_q <= 1'b1;
    end else if (rem_q != '0) begin
      rem_q    <= rem_q - 3'd1;
      strobe_q <= 1'b1;
    end else begin
      strobe_q <= 1'b0;
    end
  end

  // Output byte and remaining digits.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= dnlcd_pkg::CmdSetAddr | {1'b0, req_i.data.addr};
      cmd_q    <= 1'b1;
      last_q   <= 1'b0;
      digits_q <= aligned;
    end else if (rem_q != '0) begin
      byte_q   <= dnlcd_pkg::AsciiZero | {4'b0000, digits_q[dnlcd_pkg::BcdWidth-1 -: 4]};
      cmd_q    <= 1'b0;
      last_q   <= (rem_q == 3'd1);
      digits_q <= digits_q << 4;
    end
  end

  assign strobe_o     = strobe_q;
  assign lcd_byte_o   = byte_q;
  assign is_command_o = cmd_q;
  assign last_byte_o  = last_q;

endmodule

[rtl/decimal_number_to_lcd_bytes.sv]
// Decimal number to display bytes: set-address command, then 2 to 5 ASCII digits.
// The command byte is strobed once the request has passed the conversion chain, and the digits
// follow it. A request yields 3 to 6 bytes, one per cycle. The chain takes new requests while
// earlier ones are still converted or sent, and the byte serialiser sets the sustained rate.
// The 16-cell conversion chain stalls as a whole while a finished item at its tail waits for the serialiser.
// Reset empties the chain and the serialiser; the receiver cannot stall.
module decimal_number_to_lcd_bytes (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [dnlcd_pkg::AddrWidth-1:0]     display_address_i,
  input  logic [dnlcd_pkg::ValueWidth-1:0]    number_value_i,
  output logic                                strobe,
  output logic [7:0]                          lcd_byte_o,
  output logic                                is_command_o,
  output logic                                last_byte_o
);

  localparam int unsigned NumCells = dnlcd_pkg::NumCells;

  dnlcd_pkg::cell_data_t            chain_data  [NumCells+1];
  logic                             chain_valid [NumCells+1];
  logic [dnlcd_pkg::CountWidth-1:0] ndig;
  logic                             advance;
  logic                             ser_ready;
  dnlcd_pkg::tail_req_t             tail_req;

  // Number of digits shown, decided on the raw value.
  always_comb begin
    if (number_value_i < dnlcd_pkg::Thresh100) begin
      ndig = 3'd2;
    end else if (number_value_i < dnlcd_pkg::Thresh1000) begin
      ndig = 3'd3;
    end else if (number_value_i < dnlcd_pkg::Thresh10000) begin
      ndig = 3'd4;
    end else begin
      ndig = 3'd5;
    end
  end

  // Head of the chain: the incoming request with an empty decimal field.
  assign chain_valid[0]     = start && !busy;
  assign chain_data[0].addr = display_address_i;
  assign chain_data[0].ndig = ndig;
  assign chain_data[0].bcd  = '0;
  assign chain_data[0].bin  = number_value_i;

  // The chain moves unless a finished item waits for the serialiser.
  assign advance = !chain_valid[NumCells] || ser_ready;
  assign busy    = !advance;

  // One double-dabble step per cell.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    dnlcd_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .valid_i   (chain_valid[k]),
      .data_i    (chain_data[k]),
      .valid_o   (chain_valid[k+1]),
      .data_o    (chain_data[k+1])
    );
  end

  // Serialiser fed from the tail of the chain.
  assign tail_req.valid = chain_valid[NumCells];
  assign tail_req.data  = chain_data[NumCells];

  dnlcd_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (tail_req),
    .ready_o      (ser_ready),
    .strobe_o     (strobe),
    .lcd_byte_o   (lcd_byte_o),
    .is_command_o (is_command_o),
    .last_byte_o  (last_byte_o)
  );

  // A command byte is always followed by a digit byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && is_command_o |=> strobe && !is_command_o)
    else $error("command byte not followed by a digit");

  // The final byte of a number is never the command byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && last_byte_o |-> !is_command_o)
    else $error("last marker on a command byte");

  // Digit bytes are ASCII decimal digits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !is_command_o |-> (lcd_byte_o[7:4] == 4'h3) && (lcd_byte_o[3:0] <= 4'd9))
    else $error("digit byte out of range");

  // The block only holds requests off while a finished item waits at the tail.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> chain_valid[NumCells] && !ser_ready)
    else $error("busy without a waiting item");

endmodule
